// ===== rtl/core/avi_pkg.sv =====
package avi_pkg;

  // Ring geometry and field widths
  localparam int Window     = 64;
  localparam int SampleBits = 12;
  localparam int PosW       = (Window > 1) ? $clog2(Window) : 1;
  localparam int SumW       = SampleBits + $clog2(Window + 1);
  localparam int GainW      = 24;
  localparam int ProdW      = SumW + GainW;
  localparam int ShrW       = ProdW - 8;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 32;

  // Register reset values
  localparam logic [23:0] GainRst     = 24'd640;
  localparam logic [31:0] ZeroRst     = 32'd327680;
  localparam logic [15:0] StepRst     = 16'd6554;
  localparam logic [30:0] DeadbandRst = 31'd3277;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN     = 2'd0,
    CFG_ZERO     = 2'd1,
    CFG_STEP     = 2'd2,
    CFG_DEADBAND = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FUNC_STORE = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_CALIB = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RING,
    ST_MUL,
    ST_ZERO,
    ST_OFFS,
    ST_STEP,
    ST_VEL,
    ST_CALIB,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic capture;   // latch input payload
    logic ring_wr;   // update ring, sum and position
    logic mul;       // window sum times gain
    logic zero;      // shift, clamp, subtract zero level
    logic offs;      // subtract calibration offset
    logic step;      // acceleration times time step
    logic vel;       // velocity update with deadband
    logic calib;     // store offset, clear velocity
    logic load_out;  // move result into the output register
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       out_free;
  } status_t;

  // Saturate a 34-bit signed value to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic [33:0] x);
    logic [31:0] r;
    if (!x[33] && (x[32:31] != 2'b00)) begin
      r = 32'h7FFF_FFFF;
    end else if (x[33] && (x[32:31] != 2'b11)) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/avi_ctrl.sv =====
module avi_ctrl import avi_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        // Dispatch on the captured function code
        case (status_i.func)
          FUNC_STORE: state_d = ST_IDLE;
          FUNC_TICK, FUNC_CALIB: begin
            cmd_o.mul = 1'b1;
            state_d = ST_ZERO;
          end
          default: state_d = ST_IDLE;
        endcase
        if (status_i.func == FUNC_STORE) begin
          cmd_o.ring_wr = 1'b1;
        end
      end
      ST_ZERO: begin
        cmd_o.zero = 1'b1;
        state_d = (status_i.func == FUNC_CALIB) ? ST_CALIB : ST_OFFS;
      end
      ST_OFFS: begin
        cmd_o.offs = 1'b1;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        state_d = ST_VEL;
      end
      ST_VEL: begin
        cmd_o.vel = 1'b1;
        state_d = ST_DONE;
      end
      ST_CALIB: begin
        cmd_o.calib = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register can take the result
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_RING: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/avi_dp.sv =====
module avi_dp import avi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic [1:0]          func_i,
  input  logic [11:0]         sample_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                report_kind_o,
  output logic signed [31:0]  accel_out_o,
  output logic signed [31:0]  velocity_out_o
);

  // Configuration registers
  logic [GainW-1:0] gain_q;
  logic [31:0]      zero_q;
  logic [15:0]      step_q;
  logic [30:0]      deadband_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= GainRst;
      zero_q     <= ZeroRst;
      step_q     <= StepRst;
      deadband_q <= DeadbandRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GAIN:     gain_q     <= cfg_data_i[GainW-1:0];
        CFG_ZERO:     zero_q     <= cfg_data_i[31:0];
        CFG_STEP:     step_q     <= cfg_data_i[15:0];
        CFG_DEADBAND: deadband_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Captured input payload
  logic [1:0]            func_q;
  logic [SampleBits-1:0] sample_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q   <= func_i;
      sample_q <= sample_i[SampleBits-1:0];
    end
  end

  // Sample ring: memory plus per-entry valid bits, unwritten entries read zero
  logic [SampleBits-1:0] ring_mem [Window];
  logic [SampleBits-1:0] ring_rd_q;
  logic [Window-1:0]     ring_vld_q;
  logic [PosW-1:0]       pos_q;
  logic [SumW-1:0]       sum_q;
  logic [SampleBits-1:0] old_sample;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ring_wr) begin
      ring_mem[pos_q] <= sample_q;
    end
    ring_rd_q <= ring_mem[pos_q];
  end

  assign old_sample = ring_vld_q[pos_q] ? ring_rd_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_vld_q <= '0;
      pos_q      <= '0;
      sum_q      <= '0;
    end else if (cmd_i.ring_wr) begin
      ring_vld_q[pos_q] <= 1'b1;
      sum_q <= sum_q - SumW'(old_sample) + SumW'(sample_q);
      if (pos_q == PosW'(Window - 1)) begin
        pos_q <= '0;
      end else begin
        pos_q <= pos_q + PosW'(1);
      end
    end
  end

  // Acceleration and velocity arithmetic
  logic [ProdW-1:0] prod_q;
  logic [31:0]      raw_q;
  logic [31:0]      acc_q;
  logic [32:0]      delta_q;
  logic [31:0]      vel_acc_q;
  logic [31:0]      calib_q;

  logic [ShrW-1:0]    shr;
  logic [31:0]        scaled;
  logic signed [48:0] step_prod;
  logic [31:0]        vel_sum;
  logic signed [32:0] vel_ext;
  logic signed [32:0] db_ext;
  logic               in_band;

  always_comb begin
    shr = prod_q[ProdW-1:8];
    if (shr > ShrW'(32'h7FFF_FFFF)) begin
      scaled = 32'h7FFF_FFFF;
    end else begin
      scaled = shr[31:0];
    end
    step_prod = $signed(acc_q) * $signed({1'b0, step_q});
    vel_sum   = sat32({{2{vel_acc_q[31]}}, vel_acc_q} + {delta_q[32], delta_q});
    vel_ext   = $signed({vel_sum[31], vel_sum});
    db_ext    = $signed({2'b00, deadband_q});
    in_band   = (vel_ext < db_ext) && (vel_ext > -db_ext);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= ProdW'(sum_q) * ProdW'(gain_q);
    end
    if (cmd_i.zero) begin
      raw_q <= sat32({2'b00, scaled} - {{2{zero_q[31]}}, zero_q});
    end
    if (cmd_i.offs) begin
      acc_q <= sat32({{2{raw_q[31]}}, raw_q} - {{2{calib_q[31]}}, calib_q});
    end
    if (cmd_i.step) begin
      delta_q <= step_prod[48:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_acc_q <= '0;
      calib_q   <= '0;
    end else if (cmd_i.vel) begin
      vel_acc_q <= in_band ? 32'd0 : vel_sum;
    end else if (cmd_i.calib) begin
      vel_acc_q <= '0;
      calib_q   <= raw_q;
    end
  end

  // Output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      report_kind_o  <= (func_q == FUNC_CALIB);
      accel_out_o    <= (func_q == FUNC_CALIB) ? 32'sd0 : $signed(acc_q);
      velocity_out_o <= $signed(vel_acc_q);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.func     = func_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

endmodule

// ===== rtl/core/accel_velocity_integrator.sv =====
// Accelerometer velocity integrator with deadband.
//
// Input channel (in_valid_i / in_stall_o) carries one item per transfer:
// func_i selects store sample, tick, or calibrate; sample_i is the raw ADC
// reading for a store. Output channel (out_valid_o / out_stall_i) carries
// one report per tick or calibrate; stores and unused codes make none.
// Registers are written through cfg_we_i / cfg_index_i / cfg_data_i. The
// user must write them only while the block is idle (not enforced).
//
// One item is processed at a time by a sequencer driving a shared datapath.
// A store does a ring read, then a read-modify-write of the ring memory,
// sum and position. A tick runs multiply, zero level, offset, time-step
// multiply, velocity and load; a calibrate runs multiply, zero level,
// calibrate and load.
//
// Reset clears the ring valid bits, sum, position, velocity and offset,
// and loads the register defaults. When the receiver stalls, the result
// sits in the output register; the sequencer waits in its last step only
// if a second result is ready before the first transfer completes.
module accel_velocity_integrator import avi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          func_i,
  input  logic [11:0]         sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                report_kind_o,
  output logic signed [31:0]  accel_out_o,
  output logic signed [31:0]  velocity_out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  // Sequencer: steps each item through the datapath
  avi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: ring, arithmetic, registers and output stage
  avi_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .func_i         (func_i),
    .sample_i       (sample_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .report_kind_o  (report_kind_o),
    .accel_out_o    (accel_out_o),
    .velocity_out_o (velocity_out_o)
  );

endmodule
